// File: design/mte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mte_pkg: shared types and constants of the MIDI track event encoder
// Holds the command format between front and back, the state and register
// codes, and the fixed byte patterns of the meta events.
// ----------------------------------------------------------------------------
package mte_pkg;

   // Delta time width and its variable-length quantity layout.
   localparam int DELTA_BITS = 28;
   localparam logic [DELTA_BITS-1:0] DELTA_MAX = '1;
   localparam int VLQ_GROUPS = (DELTA_BITS + 6) / 7;
   localparam int VLQ_BITS = VLQ_GROUPS * 7;

   // Register reset values.
   localparam logic [15:0] UPT_RESET = 16'd1042;
   localparam logic [31:0] TIMEOUT_RESET = 32'd10000000;
   localparam logic [23:0] TEMPO_RESET = 24'd500000;

   // Byte values.
   localparam logic [7:0] STATUS_CLOCK = 8'hF8;
   localparam logic [7:0] STATUS_SENSING = 8'hFE;
   localparam logic [7:0] META_PREFIX = 8'hFF;
   localparam logic [7:0] META_TEMPO = 8'h51;
   localparam logic [7:0] META_TIMESIG = 8'h58;
   localparam logic [7:0] META_END = 8'h2F;
   localparam logic [7:0] TS_CLOCKS = 8'h18;
   localparam logic [7:0] TS_32NDS = 8'h08;
   localparam logic [7:0] VLQ_CONT = 8'h80;

   // Last step of the take preamble and of End of Track.
   localparam logic [3:0] META_LAST = 4'd15;
   localparam logic [3:0] EOT_LAST = 4'd3;

   typedef enum logic [1:0] {
      CSR_UNITS_PER_TICK = 2'd0,
      CSR_SILENCE_TIMEOUT = 2'd1,
      CSR_TEMPO = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_DELTA,
      CMD_EOT
   } cmd_kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_META,
      BK_EOT,
      BK_VLQ,
      BK_MSG
   } back_state_type;

   typedef struct packed {
      logic [15:0] units_per_tick;
      logic [31:0] silence_timeout;
      logic [23:0] tempo;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [DELTA_BITS-1:0] delta;
      logic [7:0] status_byte;
      logic [7:0] data_one;
      logic [7:0] data_two;
      logic [1:0] msg_len;
   } cmd_type;

   // Tempo and 4/4 time signature meta events, each with delta 0.
   function automatic logic [7:0] meta_byte(input logic [3:0] idx, input logic [23:0] tempo);
      logic [7:0] b;
      case (idx)
         4'd0: b = 8'h00;
         4'd1: b = META_PREFIX;
         4'd2: b = META_TEMPO;
         4'd3: b = 8'h03;
         4'd4: b = tempo[23:16];
         4'd5: b = tempo[15:8];
         4'd6: b = tempo[7:0];
         4'd7: b = 8'h00;
         4'd8: b = META_PREFIX;
         4'd9: b = META_TIMESIG;
         4'd10: b = 8'h04;
         4'd11: b = 8'h04;
         4'd12: b = 8'h02;
         4'd13: b = TS_CLOCKS;
         4'd14: b = TS_32NDS;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // End of Track meta event with delta 0.
   function automatic logic [7:0] eot_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd1: b = META_PREFIX;
         2'd2: b = META_END;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// File: design/mte_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mte_front: timekeeping and event classification
// Tracks ticks, the unit remainder and silence, and turns each beat that
// produces bytes into one command for the back end.
// ----------------------------------------------------------------------------
module mte_front
   import mte_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        push,
   input  wire logic        q_full,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_status_byte,
   input  wire logic [7:0]  req_data_one,
   input  wire logic [7:0]  req_data_two,
   input  wire logic [1:0]  req_msg_len,
   output logic             cmd_push,
   output cmd_type          cmd
);

   logic                  recording_ff, recording_in;
   logic [DELTA_BITS-1:0] tick_ff, tick_in;
   logic [15:0]           rem_ff, rem_in;
   logic [31:0]           idle_ff, idle_in;

   logic                  accept;
   logic [15:0]           upt;
   logic [15:0]           rem_inc;
   logic [31:0]           idle_inc;
   logic                  round_up;
   logic [DELTA_BITS-1:0] delta;
   logic                  is_message;

   assign accept = push && !q_full;

   // Next state and command for the accepted beat.
   always_comb begin
      recording_in = recording_ff;
      tick_in = tick_ff;
      rem_in = rem_ff;
      idle_in = idle_ff;
      cmd_push = 1'b0;

      upt = (cfg.units_per_tick == 16'd0) ? 16'd1 : cfg.units_per_tick;
      rem_inc = rem_ff + 16'd1;
      idle_inc = (idle_ff == 32'hFFFF_FFFF) ? idle_ff : idle_ff + 32'd1;
      round_up = ({rem_ff, 1'b0} >= {1'b0, upt});
      delta = (round_up && tick_ff != DELTA_MAX) ? tick_ff + 1'b1 : tick_ff;
      is_message = (req_msg_len != 2'd0) && (req_status_byte != STATUS_SENSING)
                   && (req_status_byte != STATUS_CLOCK);

      cmd.kind = CMD_EOT;
      cmd.delta = delta;
      cmd.status_byte = req_status_byte;
      cmd.data_one = req_data_one;
      cmd.data_two = req_data_two;
      cmd.msg_len = req_msg_len;

      if (accept) begin
         if (!req_action) begin
            // One base time unit: advance the tick and, while recording, the silence counter.
            if (rem_inc >= upt) begin
               rem_in = 16'd0;
               if (tick_ff != DELTA_MAX) begin
                  tick_in = tick_ff + 1'b1;
               end
            end else begin
               rem_in = rem_inc;
            end
            if (recording_ff) begin
               idle_in = idle_inc;
               if (idle_inc > cfg.silence_timeout) begin
                  cmd_push = 1'b1;
                  cmd.kind = CMD_EOT;
                  recording_in = 1'b0;
                  idle_in = 32'd0;
               end
            end
         end else if (is_message) begin
            // A recorded message: first of a take opens it, later ones carry a delta.
            cmd_push = 1'b1;
            cmd.kind = recording_ff ? CMD_DELTA : CMD_START;
            recording_in = 1'b1;
            tick_in = '0;
            rem_in = 16'd0;
            idle_in = 32'd0;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         recording_ff <= 1'b0;
         tick_ff <= '0;
         rem_ff <= 16'd0;
         idle_ff <= 32'd0;
      end else begin
         recording_ff <= recording_in;
         tick_ff <= tick_in;
         rem_ff <= rem_in;
         idle_ff <= idle_in;
      end
   end

endmodule
`default_nettype wire

// File: design/mte_cmdq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mte_cmdq: two-entry command queue
// Decouples the front end from the byte serializer so each can stall alone.
// ----------------------------------------------------------------------------
module mte_cmdq
   import mte_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_push,
   input  wire cmd_type q_din,
   output logic         q_full,
   input  wire logic    q_pop,
   output logic         q_empty,
   output cmd_type      q_dout
);

   cmd_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign q_full = (count_ff == 2'd2);
   assign q_empty = (count_ff == 2'd0);
   assign do_push = q_push && !q_full;
   assign do_pop = q_pop && !q_empty;
   assign q_dout = mem_ff[rd_ff];

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= q_din;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ff <= !wr_ff;
         end
         if (do_pop) begin
            rd_ff <= !rd_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

// File: design/mte_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mte_back: track byte serializer
// Expands one command into its track bytes, one per cycle while there is room,
// into a two-entry result buffer.
// ----------------------------------------------------------------------------
module mte_back
   import mte_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [23:0] tempo,
   input  wire logic        q_empty,
   input  wire cmd_type     q_dout,
   output logic             q_pop,
   input  wire logic        pop,
   output logic             empty,
   output logic [7:0]       rsp_track_byte,
   output logic             rsp_last
);

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff;
   logic [3:0]     idx_ff, idx_in;

   logic [VLQ_BITS-1:0] delta_ext;
   logic [3:0]          ngroups;
   logic [3:0]          grp_sel;
   logic [7:0]          vlq_byte;
   logic [7:0]          msg_byte;
   logic                emit;
   logic [7:0]          emit_byte;
   logic                emit_last;
   logic                room;

   logic [7:0] obuf_byte_ff [2];
   logic       obuf_last_ff [2];
   logic       obuf_wr_ff, obuf_rd_ff;
   logic [1:0] obuf_count_ff;
   logic       obuf_push, obuf_pop;

   assign room = (obuf_count_ff != 2'd2);

   // Delta as groups of seven bits, most significant nonzero group first.
   always_comb begin
      delta_ext = VLQ_BITS'(cmd_ff.delta);
      ngroups = 4'd1;
      for (int g = 1; g < VLQ_GROUPS; g++) begin
         if ((delta_ext >> (7 * g)) != '0) begin
            ngroups = 4'(g + 1);
         end
      end
      grp_sel = ngroups - 4'd1 - idx_ff;
      vlq_byte = 8'h00;
      for (int g = 0; g < VLQ_GROUPS; g++) begin
         if (grp_sel == 4'(g)) begin
            vlq_byte = {1'b0, delta_ext[7*g +: 7]} | ((g != 0) ? VLQ_CONT : 8'h00);
         end
      end
   end

   // Message byte at the current step.
   always_comb begin
      case (idx_ff[1:0])
         2'd0: msg_byte = cmd_ff.status_byte;
         2'd1: msg_byte = cmd_ff.data_one;
         default: msg_byte = cmd_ff.data_two;
      endcase
   end

   // Outputs of the serializer.
   always_comb begin
      q_pop = 1'b0;
      emit = 1'b0;
      emit_byte = 8'h00;
      emit_last = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            q_pop = !q_empty;
         end
         BK_META: begin
            emit = 1'b1;
            emit_byte = meta_byte(idx_ff, tempo);
         end
         BK_EOT: begin
            emit = 1'b1;
            emit_byte = eot_byte(idx_ff[1:0]);
            emit_last = (idx_ff == EOT_LAST);
         end
         BK_VLQ: begin
            emit = 1'b1;
            emit_byte = vlq_byte;
         end
         BK_MSG: begin
            emit = 1'b1;
            emit_byte = msg_byte;
            emit_last = (idx_ff[1:0] == cmd_ff.msg_len - 2'd1);
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Next state of the serializer.
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      unique case (state_ff)
         BK_IDLE: begin
            idx_in = 4'd0;
            if (!q_empty) begin
               case (q_dout.kind)
                  CMD_START: state_in = BK_META;
                  CMD_DELTA: state_in = BK_VLQ;
                  default: state_in = BK_EOT;
               endcase
            end
         end
         BK_META: begin
            if (room) begin
               idx_in = idx_ff + 4'd1;
               if (idx_ff == META_LAST) begin
                  state_in = BK_MSG;
                  idx_in = 4'd0;
               end
            end
         end
         BK_EOT: begin
            if (room) begin
               idx_in = idx_ff + 4'd1;
               if (idx_ff == EOT_LAST) begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_VLQ: begin
            if (room) begin
               idx_in = idx_ff + 4'd1;
               if (idx_ff == ngroups - 4'd1) begin
                  state_in = BK_MSG;
                  idx_in = 4'd0;
               end
            end
         end
         BK_MSG: begin
            if (room) begin
               idx_in = idx_ff + 4'd1;
               if (emit_last) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Serializer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         idx_ff <= 4'd0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

   // Command held while its bytes go out.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_dout;
      end
   end

   // Result buffer.
   assign obuf_push = emit && room;
   assign obuf_pop = pop && !empty;
   assign empty = (obuf_count_ff == 2'd0);
   assign rsp_track_byte = obuf_byte_ff[obuf_rd_ff];
   assign rsp_last = obuf_last_ff[obuf_rd_ff];

   always_ff @(posedge clock) begin
      if (obuf_push) begin
         obuf_byte_ff[obuf_wr_ff] <= emit_byte;
         obuf_last_ff[obuf_wr_ff] <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obuf_wr_ff <= 1'b0;
         obuf_rd_ff <= 1'b0;
         obuf_count_ff <= 2'd0;
      end else begin
         if (obuf_push) begin
            obuf_wr_ff <= !obuf_wr_ff;
         end
         if (obuf_pop) begin
            obuf_rd_ff <= !obuf_rd_ff;
         end
         if (obuf_push && !obuf_pop) begin
            obuf_count_ff <= obuf_count_ff + 2'd1;
         end else if (obuf_pop && !obuf_push) begin
            obuf_count_ff <= obuf_count_ff - 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

// File: design/midi_track_event_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midi_track_event_encoder_core: MIDI track event encoder
// Turns timed MIDI messages into Standard MIDI File track data bytes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Beat
//  req      in         push / full             one time unit or one message
//  rsp      out        empty / pop             one track byte, last on final
//  csr      in         csr_valid / csr_ready   one register write
//
// A time unit beat yields no bytes unless the take times out. A beat that
// yields N bytes (2 to 19) occupies the serializer while it loads the
// command and then emits one byte per cycle while the result buffer has room.
// The serializer is the rate limit; a two-entry command queue lets the front
// end keep accepting beats meanwhile. Reset is synchronous and clears all
// control state at once; full is high only while the command queue is full.
// ----------------------------------------------------------------------------
module midi_track_event_encoder_core
   import mte_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_status_byte,
   input  wire logic [7:0]  req_data_one,
   input  wire logic [7:0]  req_data_two,
   input  wire logic [1:0]  req_msg_len,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_track_byte,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    q_push, q_pop, q_empty;
   cmd_type q_din, q_dout;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.units_per_tick <= UPT_RESET;
         cfg_ff.silence_timeout <= TIMEOUT_RESET;
         cfg_ff.tempo <= TEMPO_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_UNITS_PER_TICK: cfg_ff.units_per_tick <= csr_wdata[15:0];
            CSR_SILENCE_TIMEOUT: cfg_ff.silence_timeout <= csr_wdata;
            CSR_TEMPO: cfg_ff.tempo <= csr_wdata[23:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   mte_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .push            (push),
      .q_full          (full),
      .req_action      (req_action),
      .req_status_byte (req_status_byte),
      .req_data_one    (req_data_one),
      .req_data_two    (req_data_two),
      .req_msg_len     (req_msg_len),
      .cmd_push        (q_push),
      .cmd             (q_din)
   );

   mte_cmdq u_cmdq (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_din   (q_din),
      .q_full  (full),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_dout  (q_dout)
   );

   mte_back u_back (
      .clock          (clock),
      .reset          (reset),
      .tempo          (cfg_ff.tempo),
      .q_empty        (q_empty),
      .q_dout         (q_dout),
      .q_pop          (q_pop),
      .pop            (pop),
      .empty          (empty),
      .rsp_track_byte (rsp_track_byte),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire

// File: design/mte_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mte_checker: port-level checks of the MIDI track event encoder
// Watches the top level's ports and flags behavior the design must not show.
// ----------------------------------------------------------------------------
module mte_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        full,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [7:0]  rsp_track_byte,
   input wire logic        rsp_last,
   input wire logic        csr_valid,
   input wire logic        csr_ready
);

   // Reset leaves no bytes behind, and a byte needs queue and serializer stages.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty ##1 empty ##1 empty)
      else $error("track byte appeared too soon after reset");

   // The command queue is drained by reset.
   a_reset_not_full: assert property (@(posedge clock)
      reset |=> !full)
      else $error("input side full right after reset");

   // A waiting byte holds until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_track_byte) && $stable(rsp_last)))
      else $error("waiting track byte changed or vanished");

   // Register writes are never stalled.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind midi_track_event_encoder_core mte_checker u_checker (.*);
`default_nettype wire
